// ===== design/tsk_pkg.sv =====
package tsk_pkg;

    localparam int DEF_NUM_NODES = 16;
    localparam int DEF_MAX_OUT   = 8;

    localparam int ID_W       = 4;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic [REQ_W-1:0] REQ_ADD_NODE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_EDGE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SORT     = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NODE_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EDGE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CYCLE     = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic idx_zero;
        logic idx_inc;
        logic clr_deg;
        logic load_walk;
        logic edge_rd;
        logic deg_inc;
        logic push_idx;
        logic pop;
        logic deg_dec;
        logic emit_final;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic sort_acc;
        logic idx_last;
        logic idx_present;
        logic walk_more;
        logic stack_empty;
        logic pend_valid;
    } sts_t;

endpackage

// ===== design/topological_sort_kahn.sv =====
// Dependency graph builder with a Kahn topological sort.
// Input channel s_*: one request per transfer (add node, add edge, sort).
// Result channel m_*: one result per transfer; m_tlast marks the last result of a
// request and m_tuser says that the node field carries a sorted node.
// Add requests give one result, registered at the transfer; a new request is taken
// in the cycle the previous result is taken or the output is empty, so back-to-back
// add requests run at one per cycle while the receiver takes every result.
// A sort blocks the input until its last result has been registered. It walks the
// T table entries (NUM_NODES, at most 16) in steps: degree clear, degree count over
// the edges of present sources, seed of the zero-degree nodes, then the pop walk
// that decrements the degrees of each sorted node's targets. Edges come from the
// edge memory through its registered read. The sorted nodes stream out one behind
// the pop, the last one carrying status. A stalled receiver holds the result
// register and pauses the walk at the next pop; nothing is dropped.
// Reset (aresetn low, synchronous) empties the graph: no nodes, empty edge lists.
module topological_sort_kahn #(
    parameter int NUM_NODES = tsk_pkg::DEF_NUM_NODES,
    parameter int MAX_OUT   = tsk_pkg::DEF_MAX_OUT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] req_type, [5:2] node_id, [9:6] target_id
    input  logic [tsk_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] out_node, [5:4] status
    output logic [tsk_pkg::OUT_DATA_W-1:0] m_tdata,
    // [0] node_valid
    output logic                           m_tuser,
    output logic                           m_tlast
);

    tsk_pkg::cmd_t cmd;
    tsk_pkg::sts_t sts;

    tsk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsk_datapath #(
        .NUM_NODES (NUM_NODES),
        .MAX_OUT   (MAX_OUT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    assign s_tready = cmd.in_ready;

endmodule

// ===== design/tsk_ctrl.sv =====
module tsk_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  tsk_pkg::sts_t sts,
    output tsk_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_CNT_NODE = 4'd2;
    localparam logic [3:0] S_CNT_RD   = 4'd3;
    localparam logic [3:0] S_CNT_UPD  = 4'd4;
    localparam logic [3:0] S_SEED     = 4'd5;
    localparam logic [3:0] S_POP      = 4'd6;
    localparam logic [3:0] S_DEC_RD   = 4'd7;
    localparam logic [3:0] S_DEC_UPD  = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.in_ready = sts.out_free;
                if (sts.sort_acc) begin
                    state_next = S_CLR;
                end
            end
            S_CLR: begin
                cmd.clr_deg = 1'b1;
                if (sts.idx_last) begin
                    cmd.idx_zero = 1'b1;
                    state_next   = S_CNT_NODE;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            // only present sources contribute to in-degrees
            S_CNT_NODE: begin
                if (sts.idx_present) begin
                    cmd.load_walk = 1'b1;
                    state_next    = S_CNT_RD;
                end else if (sts.idx_last) begin
                    cmd.idx_zero = 1'b1;
                    state_next   = S_SEED;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CNT_RD: begin
                if (sts.walk_more) begin
                    cmd.edge_rd = 1'b1;
                    state_next  = S_CNT_UPD;
                end else if (sts.idx_last) begin
                    cmd.idx_zero = 1'b1;
                    state_next   = S_SEED;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_CNT_NODE;
                end
            end
            S_CNT_UPD: begin
                cmd.deg_inc = 1'b1;
                state_next  = S_CNT_RD;
            end
            S_SEED: begin
                cmd.push_idx = 1'b1;
                if (sts.idx_last) begin
                    state_next = S_POP;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            // popping hands the previous node to the output, so it needs a free slot
            S_POP: begin
                if (sts.stack_empty) begin
                    state_next = S_FINISH;
                end else if (!sts.pend_valid || sts.out_free) begin
                    cmd.pop    = 1'b1;
                    state_next = S_DEC_RD;
                end
            end
            S_DEC_RD: begin
                if (sts.walk_more) begin
                    cmd.edge_rd = 1'b1;
                    state_next  = S_DEC_UPD;
                end else begin
                    state_next = S_POP;
                end
            end
            S_DEC_UPD: begin
                cmd.deg_dec = 1'b1;
                state_next  = S_DEC_RD;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tsk_datapath.sv =====
module tsk_datapath #(
    parameter int NUM_NODES = tsk_pkg::DEF_NUM_NODES,
    parameter int MAX_OUT   = tsk_pkg::DEF_MAX_OUT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic [tsk_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [tsk_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  tsk_pkg::cmd_t                     cmd,
    output tsk_pkg::sts_t                     sts
);

    localparam int ID_LIM     = 2 ** tsk_pkg::ID_W;
    localparam int NODE_CNT   = (NUM_NODES < ID_LIM) ? NUM_NODES : ID_LIM;
    localparam int NID_W      = $clog2(NODE_CNT);
    localparam int CNT_W      = $clog2(NUM_NODES + 1);
    localparam int FILL_W     = $clog2(MAX_OUT + 1);
    localparam int EDGE_DEPTH = NODE_CNT * MAX_OUT;
    localparam int EA_W       = $clog2(EDGE_DEPTH);
    localparam int DEG_W      = $clog2(EDGE_DEPTH + 1);
    localparam int SP_W       = $clog2(NODE_CNT + 1);

    logic [tsk_pkg::REQ_W-1:0] req;
    logic [tsk_pkg::ID_W-1:0]  nid, tid;
    logic [NID_W-1:0]          s_idx, t_idx;
    logic                      acc, node_ok, tgt_ok, add_node_ok, add_edge_ok;

    logic [NODE_CNT-1:0]       present_reg;
    logic [CNT_W-1:0]          ins_reg;
    logic [FILL_W-1:0]         fill_reg [NODE_CNT];
    logic [tsk_pkg::ID_W-1:0]  edge_mem [EDGE_DEPTH];
    logic [tsk_pkg::ID_W-1:0]  edge_rd_reg;
    logic [DEG_W-1:0]          deg_reg [NODE_CNT];
    logic [NID_W-1:0]          stack_reg [NODE_CNT];
    logic [SP_W-1:0]           sp_reg;
    logic [NID_W-1:0]          idx_reg, wnode_reg, pend_reg;
    logic [FILL_W-1:0]         slot_reg;
    logic                      pend_valid_reg;
    logic [SP_W-1:0]           sorted_reg;

    logic [tsk_pkg::ID_W-1:0]     out_node_reg;
    logic                         out_flag_reg;
    logic [tsk_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_last_reg;
    logic                         m_tvalid_reg;

    logic [NID_W-1:0]          fill_rd_idx;
    logic [FILL_W-1:0]         fill_rd;
    logic [EA_W-1:0]           wr_addr, rd_addr;
    logic                      edge_wr;
    logic [NID_W-1:0]          e_idx;
    logic [DEG_W-1:0]          deg_e;
    logic [SP_W-1:0]           sp_m1;
    logic [NID_W-1:0]          pop_node;
    logic                      push_en;
    logic [NID_W-1:0]          push_val;
    logic                      out_free;

    logic                         out_ld;
    logic [tsk_pkg::ID_W-1:0]     out_node_d;
    logic                         out_flag_d;
    logic [tsk_pkg::STATUS_W-1:0] out_status_d;
    logic                         out_last_d;

    assign req   = s_tdata[1:0];
    assign nid   = s_tdata[5:2];
    assign tid   = s_tdata[9:6];
    assign s_idx = nid[NID_W-1:0];
    assign t_idx = tid[NID_W-1:0];
    assign acc   = s_tvalid && cmd.in_ready;

    assign node_ok = 32'(nid) < NUM_NODES;
    assign tgt_ok  = 32'(tid) < NUM_NODES;

    // one read port on the fill counts: the request side while the input is open, the walk otherwise
    assign fill_rd_idx = cmd.in_ready ? s_idx : wnode_reg;
    assign fill_rd     = fill_reg[fill_rd_idx];

    assign add_node_ok = node_ok && (32'(ins_reg) < NUM_NODES);
    assign add_edge_ok = node_ok && tgt_ok && (32'(fill_rd) < MAX_OUT);
    assign edge_wr     = acc && (req == tsk_pkg::REQ_ADD_EDGE) && add_edge_ok;

    assign wr_addr = EA_W'(32'(s_idx) * MAX_OUT + 32'(fill_rd));
    assign rd_addr = EA_W'(32'(wnode_reg) * MAX_OUT + 32'(slot_reg));

    assign e_idx    = edge_rd_reg[NID_W-1:0];
    assign deg_e    = deg_reg[e_idx];
    assign sp_m1    = sp_reg - SP_W'(1);
    assign pop_node = stack_reg[sp_m1[NID_W-1:0]];
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        push_en  = 1'b0;
        push_val = idx_reg;
        if (cmd.push_idx && present_reg[idx_reg] && (deg_reg[idx_reg] == '0)) begin
            push_en = 1'b1;
        end else if (cmd.deg_dec && (deg_e == DEG_W'(1))) begin
            push_en  = 1'b1;
            push_val = e_idx;
        end
    end

    always_comb begin
        out_ld       = 1'b0;
        out_node_d   = '0;
        out_flag_d   = 1'b0;
        out_status_d = tsk_pkg::ST_OK;
        out_last_d   = 1'b1;
        if (acc && (req != tsk_pkg::REQ_SORT)) begin
            out_ld = 1'b1;
            case (req)
                tsk_pkg::REQ_ADD_NODE: begin
                    out_status_d = add_node_ok ? tsk_pkg::ST_OK : tsk_pkg::ST_NODE_FULL;
                end
                tsk_pkg::REQ_ADD_EDGE: begin
                    out_status_d = add_edge_ok ? tsk_pkg::ST_OK : tsk_pkg::ST_EDGE_FULL;
                end
                default: begin
                    out_status_d = tsk_pkg::ST_OK;
                end
            endcase
        end else if (cmd.pop && pend_valid_reg) begin
            out_ld     = 1'b1;
            out_node_d = tsk_pkg::ID_W'(pend_reg);
            out_flag_d = 1'b1;
            out_last_d = 1'b0;
        end else if (cmd.emit_final) begin
            out_ld = 1'b1;
            if (pend_valid_reg) begin
                out_node_d   = tsk_pkg::ID_W'(pend_reg);
                out_flag_d   = 1'b1;
                out_status_d = (32'(sorted_reg) < NUM_NODES) ? tsk_pkg::ST_CYCLE
                                                             : tsk_pkg::ST_OK;
            end else begin
                out_status_d = tsk_pkg::ST_CYCLE;
            end
        end
    end

    // graph tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
            ins_reg     <= '0;
            for (int i = 0; i < NODE_CNT; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (acc) begin
            if ((req == tsk_pkg::REQ_ADD_NODE) && add_node_ok) begin
                present_reg[s_idx] <= 1'b1;
                ins_reg            <= ins_reg + CNT_W'(1);
            end
            if (edge_wr) begin
                fill_reg[s_idx] <= fill_rd + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (edge_wr) begin
            edge_mem[wr_addr] <= tid;
        end
        if (cmd.edge_rd) begin
            edge_rd_reg <= edge_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_deg) begin
            deg_reg[idx_reg] <= '0;
        end
        if (cmd.deg_inc) begin
            deg_reg[e_idx] <= deg_e + DEG_W'(1);
        end
        if (cmd.deg_dec && (deg_e != '0)) begin
            deg_reg[e_idx] <= deg_e - DEG_W'(1);
        end
        if (push_en && (32'(sp_reg) < NODE_CNT)) begin
            stack_reg[sp_reg[NID_W-1:0]] <= push_val;
        end
    end

    // sort walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg         <= '0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            sorted_reg     <= '0;
        end else begin
            if (acc && (req == tsk_pkg::REQ_SORT)) begin
                sp_reg         <= '0;
                pend_valid_reg <= 1'b0;
                idx_reg        <= '0;
                sorted_reg     <= '0;
            end
            if (cmd.idx_zero) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + NID_W'(1);
            end
            if (push_en && (32'(sp_reg) < NODE_CNT)) begin
                sp_reg <= sp_reg + SP_W'(1);
            end
            if (cmd.pop) begin
                sp_reg         <= sp_m1;
                pend_valid_reg <= 1'b1;
                sorted_reg     <= sorted_reg + SP_W'(1);
            end
            if (cmd.emit_final) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop) begin
            pend_reg  <= pop_node;
            wnode_reg <= pop_node;
            slot_reg  <= '0;
        end else if (cmd.load_walk) begin
            wnode_reg <= idx_reg;
            slot_reg  <= '0;
        end else if (cmd.edge_rd) begin
            slot_reg <= slot_reg + FILL_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ld) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld) begin
            out_node_reg   <= out_node_d;
            out_flag_reg   <= out_flag_d;
            out_status_reg <= out_status_d;
            out_last_reg   <= out_last_d;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_node_reg};
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_last_reg;

    assign sts.out_free    = out_free;
    assign sts.sort_acc    = acc && (req == tsk_pkg::REQ_SORT);
    assign sts.idx_last    = 32'(idx_reg) == (NODE_CNT - 1);
    assign sts.idx_present = present_reg[idx_reg];
    assign sts.walk_more   = slot_reg < fill_rd;
    assign sts.stack_empty = sp_reg == '0;
    assign sts.pend_valid  = pend_valid_reg;

endmodule

// ===== design/tsk_checker.sv =====
module tsk_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [tsk_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tsk_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    // a sort keeps the input closed for at least the cycle after its transfer
    a_sort_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[1:0] == tsk_pkg::REQ_SORT)) |=> !s_tready)
        else $error("input open right after a sort transfer");

    // results without a node are always single and final
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[3:0] == '0)))
        else $error("non-node result not final or node field set");

    // only the final result of a sort may carry an error
    a_mid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && !m_tlast) |-> (m_tdata[5:4] == tsk_pkg::ST_OK))
        else $error("error status on a non-final sort result");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("result changed while stalled");

endmodule

bind topological_sort_kahn tsk_checker u_tsk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
